/* sv/per_type_message_throttle_macros.svh */
// Assertion helpers for the throttle RTL, used by pmt_back.
`ifndef PER_TYPE_MESSAGE_THROTTLE_MACROS_SVH
`define PER_TYPE_MESSAGE_THROTTLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pmt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pmt check failed");

`endif

/* sv/pmt_pkg.sv */
package pmt_pkg;

    // field widths
    localparam int KIND_W   = 2;
    localparam int TYPE_W   = 8;
    localparam int TEXT_W   = 12;
    localparam int LEN_W    = 13;
    localparam int STATUS_W = 2;
    localparam int CREDIT_W = 4;
    localparam int TIMER_W  = 8;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 13;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PERI     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_THROTTLED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_CREDIT_LIMIT  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HOLDOFF_TICKS = 2'd1;
    localparam logic [CFG_IW-1:0] REG_MAX_LENGTH    = 2'd2;

    // register reset values
    localparam logic [CREDIT_W-1:0] RST_CREDIT_LIMIT  = 4'd4;
    localparam logic [TIMER_W-1:0]  RST_HOLDOFF_TICKS = 8'd20;
    localparam logic [LEN_W-1:0]    RST_MAX_LENGTH    = 13'd256;

    // bytes added by message framing
    localparam logic [LEN_W-1:0] FRAME_OVERHEAD = 13'd28;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // work the back end does for a queued request
    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_TICK,
        OP_ERR,
        OP_PERI
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TICK
    } t_back_state;

    // classified request; status is final for OP_DIRECT and the
    // pass-throttle outcome for OP_ERR / OP_PERI
    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] status;
        logic [TYPE_W-1:0]   msg_type;
        logic [LEN_W-1:0]    len;
    } t_item;

    typedef struct packed {
        logic [CREDIT_W-1:0] credit_limit;
        logic [TIMER_W-1:0]  holdoff_ticks;
        logic [LEN_W-1:0]    max_length;
    } t_cfg;

endpackage

/* sv/pmt_if.sv */
// request channel
interface pmt_req_if;
    logic                        valid;
    logic                        ready;
    logic [pmt_pkg::KIND_W-1:0]  kind;
    logic                        unthrottled;
    logic [pmt_pkg::TYPE_W-1:0]  msg_type;
    logic [pmt_pkg::TEXT_W-1:0]  text_length;

    modport source (output valid, kind, unthrottled, msg_type, text_length, input ready);
    modport sink   (input valid, kind, unthrottled, msg_type, text_length, output ready);
endinterface

// result channel
interface pmt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pmt_pkg::STATUS_W-1:0]  status;
    logic [pmt_pkg::LEN_W-1:0]     message_length;

    modport source (output valid, status, message_length, input ready);
    modport sink   (input valid, status, message_length, output ready);
endinterface

// register write channel
interface pmt_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pmt_pkg::CFG_IW-1:0]  index;
    logic [pmt_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pmt_ram.sv */
module pmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pmt_front.sv */
module pmt_front #(
    parameter int ERROR_TYPES = 32,
    parameter int PERI_TYPES  = 16
) (
    pmt_req_if.sink                  i_req,
    input  logic                     i_full,
    input  logic                     i_hold,
    input  logic [pmt_pkg::LEN_W-1:0] i_max_length,
    output logic                     o_push,
    output pmt_pkg::t_item           o_item
);
    import pmt_pkg::*;

    logic [LEN_W-1:0]    framed;
    logic                too_long;
    logic [STATUS_W-1:0] pass_st;
    logic                err_ok;
    logic                peri_ok;

    // take a request whenever the queue has room and the tables are live
    assign i_req.ready = !i_full && !i_hold;
    assign o_push      = i_req.valid && i_req.ready;

    assign framed   = LEN_W'(i_req.text_length) + FRAME_OVERHEAD;
    assign too_long = framed > i_max_length;
    assign pass_st  = too_long ? ST_TOO_LONG : ST_ACCEPTED;
    assign err_ok   = {1'b0, i_req.msg_type} < (TYPE_W + 1)'(ERROR_TYPES);
    assign peri_ok  = {1'b0, i_req.msg_type} < (TYPE_W + 1)'(PERI_TYPES);

    // classify the request
    always_comb begin
        o_item.op       = OP_DIRECT;
        o_item.status   = ST_INVALID;
        o_item.msg_type = i_req.msg_type;
        o_item.len      = framed;
        unique case (i_req.kind)
            KIND_ERROR: begin
                if (i_req.unthrottled) begin
                    o_item.status = pass_st;
                end else if (err_ok) begin
                    o_item.op     = OP_ERR;
                    o_item.status = pass_st;
                end
            end
            KIND_PERI: begin
                if (i_req.unthrottled) begin
                    o_item.status = pass_st;
                end else if (peri_ok) begin
                    o_item.op     = OP_PERI;
                    o_item.status = pass_st;
                end
            end
            KIND_TICK: begin
                o_item.op     = OP_TICK;
                o_item.status = ST_ACCEPTED;
                o_item.len    = '0;
            end
            KIND_RESERVED: begin
                o_item.len = '0;
            end
        endcase
    end

endmodule

/* sv/pmt_queue.sv */
module pmt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pmt_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pmt_pkg::t_item o_item
);
    import pmt_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] r_wr;
    logic [QUEUE_PW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/pmt_back.sv */
`include "per_type_message_throttle_macros.svh"

module pmt_back #(
    parameter int ERROR_TYPES = 32,
    parameter int PERI_TYPES  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmt_pkg::t_cfg  i_cfg,
    input  logic           i_empty,
    input  pmt_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_clearing,
    pmt_rsp_if.source      o_rsp
);
    import pmt_pkg::*;

    localparam int EAW  = (ERROR_TYPES > 1) ? $clog2(ERROR_TYPES) : 1;
    localparam int PAW  = (PERI_TYPES > 1) ? $clog2(PERI_TYPES) : 1;
    localparam int MAXD = (ERROR_TYPES > PERI_TYPES) ? ERROR_TYPES : PERI_TYPES;
    localparam int CW   = $clog2(MAXD + 1);

    t_back_state         r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    t_item               r_item, n_item;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [LEN_W-1:0]    r_len, n_len;

    logic                out_free;
    logic                out_load;
    logic [CW-1:0]       widx;
    logic                ram_re;
    logic                cr_we, tm_we;
    logic [EAW-1:0]      cr_waddr, cr_raddr;
    logic [PAW-1:0]      tm_waddr, tm_raddr;
    logic [CREDIT_W-1:0] cr_wdata, cr_rdata;
    logic [TIMER_W-1:0]  tm_wdata, tm_rdata;

    pmt_ram #(.WIDTH(CREDIT_W), .DEPTH(ERROR_TYPES)) u_credit (
        .i_clk   (i_clk),
        .i_we    (cr_we),
        .i_waddr (cr_waddr),
        .i_wdata (cr_wdata),
        .i_re    (ram_re),
        .i_raddr (cr_raddr),
        .o_rdata (cr_rdata)
    );

    pmt_ram #(.WIDTH(TIMER_W), .DEPTH(PERI_TYPES)) u_timer (
        .i_clk   (i_clk),
        .i_we    (tm_we),
        .i_waddr (tm_waddr),
        .i_wdata (tm_wdata),
        .i_re    (ram_re),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign widx        = r_idx - 1'b1;
    assign o_clearing  = r_state == S_CLEAR;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.message_length = r_len;

    // sequencer: clear pass, request execution, tick sweep
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_item   = r_item;
        n_status = r_status;
        n_len    = r_len;
        o_pop    = 1'b0;
        out_load = 1'b0;
        ram_re   = 1'b0;
        cr_raddr = i_item.msg_type[EAW-1:0];
        tm_raddr = i_item.msg_type[PAW-1:0];
        cr_we    = 1'b0;
        tm_we    = 1'b0;
        cr_waddr = r_idx[EAW-1:0];
        tm_waddr = r_idx[PAW-1:0];
        cr_wdata = '0;
        tm_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                cr_we = r_idx < CW'(ERROR_TYPES);
                tm_we = r_idx < CW'(PERI_TYPES);
                if (r_idx == CW'(MAXD - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    unique case (i_item.op)
                        OP_DIRECT: begin
                            if (out_free) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_status = i_item.status;
                                n_len    = i_item.len;
                            end
                        end
                        OP_TICK: begin
                            // result is fixed, send it and sweep afterwards
                            if (out_free) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_status = ST_ACCEPTED;
                                n_len    = '0;
                                n_state  = S_TICK;
                                n_idx    = '0;
                            end
                        end
                        OP_ERR, OP_PERI: begin
                            o_pop   = 1'b1;
                            ram_re  = 1'b1;
                            n_item  = i_item;
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                // table word is in the read register now
                if (out_free) begin
                    out_load = 1'b1;
                    n_len    = r_item.len;
                    n_state  = S_IDLE;
                    if (r_item.op == OP_ERR) begin
                        cr_waddr = r_item.msg_type[EAW-1:0];
                        cr_wdata = cr_rdata + 1'b1;
                        if (cr_rdata >= i_cfg.credit_limit) begin
                            n_status = ST_THROTTLED;
                        end else begin
                            cr_we    = 1'b1;
                            n_status = r_item.status;
                        end
                    end else begin
                        tm_waddr = r_item.msg_type[PAW-1:0];
                        tm_wdata = i_cfg.holdoff_ticks;
                        if (tm_rdata != '0) begin
                            n_status = ST_THROTTLED;
                        end else begin
                            tm_we    = 1'b1;
                            n_status = r_item.status;
                        end
                    end
                end
            end
            S_TICK: begin
                // read entry idx, write back entry idx-1 decremented
                ram_re   = 1'b1;
                cr_raddr = r_idx[EAW-1:0];
                tm_raddr = r_idx[PAW-1:0];
                cr_waddr = widx[EAW-1:0];
                tm_waddr = widx[PAW-1:0];
                cr_wdata = cr_rdata - 1'b1;
                tm_wdata = tm_rdata - 1'b1;
                if (r_idx != '0) begin
                    cr_we = (widx < CW'(ERROR_TYPES)) && (cr_rdata != '0);
                    tm_we = (widx < CW'(PERI_TYPES)) && (tm_rdata != '0);
                end
                if (r_idx == CW'(MAXD)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= out_load || (r_out_valid && !o_rsp.ready);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_status <= n_status;
        r_len    <= n_len;
    end

    `PMT_ASSERT_IMP(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_pop)
    `PMT_ASSERT_IMP(a_load_into_free, i_clk, i_rst_n, out_load, out_free)
    `PMT_ASSERT_IMP(a_exec_table_op, i_clk, i_rst_n, r_state == S_EXEC,
        r_item.op == OP_ERR || r_item.op == OP_PERI)
    `PMT_ASSERT_NXT(a_sweep_ends, i_clk, i_rst_n,
        r_state == S_TICK && r_idx == CW'(MAXD), r_state == S_IDLE)

endmodule

/* sv/per_type_message_throttle.sv */
// Per-type log message throttle. Requests enter through a classifier that
// checks kind, type range and framed length (text + 28 bytes), and wait in a
// two-entry queue for the table engine. For error and peripheral messages of
// a throttled type the engine first reads the credit or holdoff word from
// its table RAM (registered read), then decides and writes it back.
// Unthrottled, out-of-range and reserved requests are answered without the
// tables. A tick answers at once and then sweeps both tables one entry per
// cycle, finishing the sweep before the next request starts.
// After reset both tables are zeroed by a clearing pass during which no
// request is taken; register writes are taken at any time and should be
// issued only while the block is idle.
module per_type_message_throttle #(
    parameter int ERROR_TYPES = 32,
    parameter int PERI_TYPES  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmt_cfg_if.sink   i_cfg,
    pmt_req_if.sink   i_req,
    pmt_rsp_if.source o_rsp
);
    import pmt_pkg::*;

    logic [CREDIT_W-1:0] r_credit_limit;
    logic [TIMER_W-1:0]  r_holdoff_ticks;
    logic [LEN_W-1:0]    r_max_length;
    t_cfg                cfg;

    logic  q_push, q_full, q_pop, q_empty, clearing;
    t_item q_in, q_out;

    // register file
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit_limit  <= RST_CREDIT_LIMIT;
            r_holdoff_ticks <= RST_HOLDOFF_TICKS;
            r_max_length    <= RST_MAX_LENGTH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_CREDIT_LIMIT:  r_credit_limit  <= i_cfg.data[CREDIT_W-1:0];
                REG_HOLDOFF_TICKS: r_holdoff_ticks <= i_cfg.data[TIMER_W-1:0];
                REG_MAX_LENGTH:    r_max_length    <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{credit_limit: r_credit_limit, holdoff_ticks: r_holdoff_ticks,
                   max_length: r_max_length};

    pmt_front #(.ERROR_TYPES(ERROR_TYPES), .PERI_TYPES(PERI_TYPES)) u_front (
        .i_req        (i_req),
        .i_full       (q_full),
        .i_hold       (clearing),
        .i_max_length (cfg.max_length),
        .o_push       (q_push),
        .o_item       (q_in)
    );

    pmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    pmt_back #(.ERROR_TYPES(ERROR_TYPES), .PERI_TYPES(PERI_TYPES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_empty    (q_empty),
        .i_item     (q_out),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

/* sim/per_type_message_throttle_tb.sv */
module per_type_message_throttle_tb;
    import pmt_pkg::*;

    localparam int ERROR_TYPES  = 32;
    localparam int PERI_TYPES   = 16;
    // a tick sweeps max(ERROR_TYPES, PERI_TYPES) entries after its reply
    localparam int SWEEP_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 200;
    localparam int HOLD_CYCLES  = 300;
    // index with no register behind it; a write must change nothing
    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              unthrottled;
        logic [TYPE_W-1:0] msg_type;
        logic [TEXT_W-1:0] text_length;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    message_length;
    } rsp_t;

    // directed row; st/len only meaningful when typed is set
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                unthrottled;
        logic [TYPE_W-1:0]   msg_type;
        logic [TEXT_W-1:0]   text_length;
        logic                typed;
        logic [STATUS_W-1:0] st;
        logic [LEN_W-1:0]    len;
    } dir_row_t;

    dir_row_t dir_tbl [25] = '{
        // credit for type 0 runs out at the reset limit of 4
        '{KIND_ERROR, 1'b0, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd28},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd228,  1'b1, ST_ACCEPTED,  13'd256},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd229,  1'b1, ST_TOO_LONG,  13'd257},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd28},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd0,    1'b1, ST_THROTTLED, 13'd28},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd4095, 1'b1, ST_THROTTLED, 13'd4123},
        '{KIND_ERROR, 1'b0, 8'd31,  12'd10,   1'b1, ST_ACCEPTED,  13'd38},
        '{KIND_ERROR, 1'b0, 8'd32,  12'd0,    1'b1, ST_INVALID,   13'd28},
        '{KIND_ERROR, 1'b0, 8'd255, 12'd4095, 1'b1, ST_INVALID,   13'd4123},
        // peripheral holdoff
        '{KIND_PERI,  1'b0, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd28},
        '{KIND_PERI,  1'b0, 8'd0,   12'd0,    1'b1, ST_THROTTLED, 13'd28},
        '{KIND_PERI,  1'b0, 8'd15,  12'd4095, 1'b1, ST_TOO_LONG,  13'd4123},
        '{KIND_PERI,  1'b0, 8'd15,  12'd0,    1'b1, ST_THROTTLED, 13'd28},
        '{KIND_PERI,  1'b0, 8'd16,  12'd0,    1'b1, ST_INVALID,   13'd28},
        // bypass ignores type and tables
        '{KIND_ERROR, 1'b1, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd28},
        '{KIND_PERI,  1'b1, 8'd255, 12'd4095, 1'b1, ST_TOO_LONG,  13'd4123},
        '{KIND_ERROR, 1'b1, 8'd200, 12'd228,  1'b1, ST_ACCEPTED,  13'd256},
        // reserved kind
        '{KIND_RESERVED, 1'b0, 8'd5,   12'd100,  1'b1, ST_INVALID, 13'd0},
        '{KIND_RESERVED, 1'b1, 8'd255, 12'd4095, 1'b1, ST_INVALID, 13'd0},
        // tick frees one credit on type 0
        '{KIND_TICK,  1'b0, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd0},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd0,    1'b1, ST_ACCEPTED,  13'd28},
        '{KIND_ERROR, 1'b0, 8'd0,   12'd0,    1'b1, ST_THROTTLED, 13'd28},
        '{KIND_TICK,  1'b1, 8'd255, 12'd4095, 1'b1, ST_ACCEPTED,  13'd0},
        '{KIND_PERI,  1'b0, 8'd0,   12'd0,    1'b0, ST_ACCEPTED,  13'd0},
        '{KIND_ERROR, 1'b0, 8'd1,   12'd100,  1'b0, ST_ACCEPTED,  13'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pmt_cfg_if cfg_ch ();
    pmt_req_if req_ch ();
    pmt_rsp_if rsp_ch ();

    per_type_message_throttle #(
        .ERROR_TYPES(ERROR_TYPES),
        .PERI_TYPES (PERI_TYPES)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_ch),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // throttle tables and registers as the block should hold them
    logic [CREDIT_W-1:0] err_credit   [ERROR_TYPES];
    logic [TIMER_W-1:0]  peri_holdoff [PERI_TYPES];
    logic [CREDIT_W-1:0] cur_credit_limit = RST_CREDIT_LIMIT;
    logic [TIMER_W-1:0]  cur_holdoff      = RST_HOLDOFF_TICKS;
    logic [LEN_W-1:0]    cur_max_length   = RST_MAX_LENGTH;

    rsp_t pending_results [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_stall_pct   = 0;
    int unsigned hold_reqs      = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // expected reply for one request; updates the tables
    function automatic rsp_t predict_throttle(req_t r);
        rsp_t             res;
        logic [LEN_W-1:0] framed;
        framed             = LEN_W'(r.text_length) + FRAME_OVERHEAD;
        res.status         = ST_ACCEPTED;
        res.message_length = framed;
        case (r.kind)
            KIND_TICK: begin
                for (int i = 0; i < ERROR_TYPES; i++)
                    if (err_credit[i] != '0) err_credit[i] = err_credit[i] - 1'b1;
                for (int i = 0; i < PERI_TYPES; i++)
                    if (peri_holdoff[i] != '0) peri_holdoff[i] = peri_holdoff[i] - 1'b1;
                res.message_length = '0;
            end
            KIND_RESERVED: begin
                res.status         = ST_INVALID;
                res.message_length = '0;
            end
            default: begin
                if (!r.unthrottled && r.kind == KIND_ERROR) begin
                    if (r.msg_type >= ERROR_TYPES)
                        res.status = ST_INVALID;
                    else if (err_credit[r.msg_type] >= cur_credit_limit)
                        res.status = ST_THROTTLED;
                    else
                        err_credit[r.msg_type] = err_credit[r.msg_type] + 1'b1;
                end else if (!r.unthrottled) begin
                    if (r.msg_type >= PERI_TYPES)
                        res.status = ST_INVALID;
                    else if (peri_holdoff[r.msg_type] != '0)
                        res.status = ST_THROTTLED;
                    else
                        peri_holdoff[r.msg_type] = cur_holdoff;
                end
                // table update stands even when the length check refuses
                if (res.status == ST_ACCEPTED && framed > cur_max_length)
                    res.status = ST_TOO_LONG;
            end
        endcase
        return res;
    endfunction

    // mostly in-range types on a few hot entries, with some noise
    function automatic req_t random_request();
        req_t        r;
        int unsigned k;
        int          b;
        k = $urandom_range(99);
        r.kind = (k < 45) ? KIND_ERROR : (k < 80) ? KIND_PERI :
                 (k < 95) ? KIND_TICK : KIND_RESERVED;
        r.unthrottled = ($urandom_range(9) == 0);
        k = $urandom_range(99);
        if (k < 50)
            r.msg_type = TYPE_W'($urandom_range(7));
        else if (k < 85)
            r.msg_type = TYPE_W'((r.kind == KIND_PERI) ? $urandom_range(PERI_TYPES - 1)
                                                       : $urandom_range(ERROR_TYPES - 1));
        else
            r.msg_type = TYPE_W'($urandom_range(255));
        k = $urandom_range(9);
        if (k < 5) begin
            r.text_length = TEXT_W'($urandom_range(300));
        end else if (k < 9) begin
            r.text_length = TEXT_W'($urandom_range(4095));
        end else begin
            // straddle the length limit
            b = int'(cur_max_length) - 29 + int'($urandom_range(2));
            if (b < 0) b = 0;
            if (b > 4095) b = 4095;
            r.text_length = TEXT_W'(b);
        end
        return r;
    endfunction

    task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_CREDIT_LIMIT:  cur_credit_limit = data[CREDIT_W-1:0];
            REG_HOLDOFF_TICKS: cur_holdoff      = data[TIMER_W-1:0];
            REG_MAX_LENGTH:    cur_max_length   = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // offer one request, with random idle cycles in front
    task automatic send_request(input req_t r, input logic typed, input rsp_t typed_rsp);
        rsp_t pred;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.kind        = r.kind;
        req_ch.unthrottled = r.unthrottled;
        req_ch.msg_type    = r.msg_type;
        req_ch.text_length = r.text_length;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pred = predict_throttle(r);
        pending_results.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // response ready: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
        end else begin
            rsp_ch.ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // compare each reply with the oldest expectation
    always @(posedge i_clk) begin
        rsp_t want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected reply: status %0d message_length %0d",
                       rsp_ch.status, rsp_ch.message_length);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.message_length !== want.message_length) begin
                    $error("message_length: expected %0d, got %0d",
                           want.message_length, rsp_ch.message_length);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        req_t r;
        rsp_t typed_rsp;
        rsp_t no_rsp;
        no_rsp = '0;
        for (int i = 0; i < ERROR_TYPES; i++) err_credit[i] = '0;
        for (int i = 0; i < PERI_TYPES; i++) peri_holdoff[i] = '0;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_ERROR;
        req_ch.unthrottled = 1'b0;
        req_ch.msg_type    = '0;
        req_ch.text_length = '0;
        rsp_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_CREDIT_LIMIT;
        cfg_ch.data        = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at reset settings
        foreach (dir_tbl[i]) begin
            r.kind                   = dir_tbl[i].kind;
            r.unthrottled            = dir_tbl[i].unthrottled;
            r.msg_type               = dir_tbl[i].msg_type;
            r.text_length            = dir_tbl[i].text_length;
            typed_rsp.status         = dir_tbl[i].st;
            typed_rsp.message_length = dir_tbl[i].len;
            send_request(r, dir_tbl[i].typed, typed_rsp);
        end

        // random phases, each with its own settings and idle pattern
        for (int p = 0; p < PHASES; p++) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            wait_results_drained();
            repeat (SWEEP_CYCLES) @(posedge i_clk);
            case (p)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    write_register(REG_CREDIT_LIMIT, 13'd15);
                    write_register(REG_HOLDOFF_TICKS, 13'd255);
                    write_register(REG_MAX_LENGTH, 13'd4123);
                    tx_idle_pct  = 78;
                    rx_stall_pct = 0;
                end
                2: begin
                    // upper data bits must be dropped
                    write_register(REG_CREDIT_LIMIT, 13'h0A31);
                    write_register(REG_HOLDOFF_TICKS, 13'h1E01);
                    write_register(REG_MAX_LENGTH, 13'd28);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 78;
                end
                3: begin
                    // zero limit refuses all, zero holdoff never blocks
                    write_register(REG_CREDIT_LIMIT, 13'd0);
                    write_register(REG_HOLDOFF_TICKS, 13'd0);
                    write_register(REG_MAX_LENGTH, 13'd8191);
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
                4: begin
                    write_register(REG_CREDIT_LIMIT, 13'd7);
                    write_register(REG_HOLDOFF_TICKS, 13'd3);
                    write_register(REG_MAX_LENGTH, 13'd1000);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                default: begin
                    write_register(REG_CREDIT_LIMIT,
                                   {9'($urandom), 4'($urandom_range(1, 15))});
                    write_register(REG_HOLDOFF_TICKS,
                                   {5'($urandom), 8'($urandom_range(1, 255))});
                    write_register(REG_MAX_LENGTH, 13'($urandom_range(8191)));
                    write_register(REG_UNUSED, 13'($urandom));
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off so the queue backs up into the input
                if (p == 4 && n == 60) hold_reqs++;
                send_request(random_request(), 1'b0, no_rsp);
            end
        end

        @(negedge i_clk);
        req_ch.valid = 1'b0;
        wait_results_drained();
        repeat (SWEEP_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
